// File: sv/esn_pkg.sv
// Shared types, codes and helper functions of the echo state reservoir step.
// Used by every module in this folder.
package esn_pkg;

  localparam int ROW_W = 6;   // neuron index, sized for the largest reservoir
  localparam int CNT_W = 7;   // counts up to and including the reservoir size
  localparam int COL_W = 7;   // weight column, sized for the widest weight row
  localparam int ACC_W = 64;

  localparam logic [1:0] OP_WEIGHT  = 2'd0;
  localparam logic [1:0] OP_CONC    = 2'd1;
  localparam logic [1:0] OP_SAMPLE  = 2'd2;
  localparam logic [1:0] OP_RESTART = 2'd3;

  localparam logic [2:0] REG_BIAS_SCALE  = 3'd0;
  localparam logic [2:0] REG_INPUT_SCALE = 3'd1;
  localparam logic [2:0] REG_INIT_STATE  = 3'd2;
  localparam logic [2:0] REG_WASHOUT     = 3'd3;
  localparam logic [2:0] REG_INPUT_COUNT = 3'd4;
  localparam logic [2:0] REG_NEURON_CNT  = 3'd5;

  localparam logic [1:0] SRC_SAMPLE = 2'd0;
  localparam logic [1:0] SRC_BIAS   = 2'd1;
  localparam logic [1:0] SRC_STATE  = 2'd2;

  localparam logic MEM_WEIGHT = 1'b0;
  localparam logic MEM_CONC   = 1'b1;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [4:0]         row_index;
    logic [5:0]         column_index;
    logic signed [15:0] data_word;
  } in_item_t;

  typedef struct packed {
    logic [4:0]         neuron_index;
    logic signed [15:0] reservoir_value;
    logic signed [15:0] projected_value;
    logic               projection_applied;
    logic               last_neuron;
  } out_item_t;

  typedef struct packed {
    logic             wr_weight;
    logic             wr_conc;
    logic             wr_sample;
    logic             restart;
    logic             start;
    logic             issue;
    logic             first;
    logic             mem_sel;
    logic [1:0]       src;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] opk;
    logic             scale_lo;
    logic             scale_hi;
    logic             scale_sum;
    logic             fin;
    logic             tanh1;
    logic             tanh2;
    logic             tanh3;
    logic             commit;
    logic             cap_res;
    logic             proj_rnd;
    logic             proj_pass;
    logic             emit;
    logic             last;
    logic             step_done;
  } cmd_t;

  typedef struct packed {
    logic             busy;
    logic             out_free;
    logic [3:0]       ni;
    logic [CNT_W-1:0] n;
    logic             applied;
  } status_t;

  // tanh at steps of 0.25, scaled by 65536.
  function automatic logic [16:0] tanh_tab(input logic [4:0] s);
    logic [16:0] v;
    unique case (s)
      5'd0:  v = 17'd0;
      5'd1:  v = 17'd16051;
      5'd2:  v = 17'd30285;
      5'd3:  v = 17'd41625;
      5'd4:  v = 17'd49911;
      5'd5:  v = 17'd55593;
      5'd6:  v = 17'd59320;
      5'd7:  v = 17'd61694;
      5'd8:  v = 17'd63179;
      5'd9:  v = 17'd64096;
      5'd10: v = 17'd64659;
      5'd11: v = 17'd65000;
      5'd12: v = 17'd65212;
      5'd13: v = 17'd65339;
      5'd14: v = 17'd65417;
      5'd15: v = 17'd65464;
      5'd16: v = 17'd65492;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
    logic signed [15:0] r;
    if (v > 64'sd32767) r = 16'sh7FFF;
    else if (v < -64'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

// File: sv/esn_ctrl.sv
// Sequencer of the reservoir step: decodes items and drives the datapath.
// Depends on esn_pkg.
module esn_ctrl #(
  parameter int MAX_INPUTS = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  esn_pkg::in_item_t in_item,
  input  esn_pkg::status_t  sts,
  output esn_pkg::cmd_t     cmd
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_INNER   = 5'd1;
  localparam logic [4:0] S_INNER_W = 5'd2;
  localparam logic [4:0] S_SCL_LO  = 5'd3;
  localparam logic [4:0] S_SCL_HI  = 5'd4;
  localparam logic [4:0] S_SCL_SUM = 5'd5;
  localparam logic [4:0] S_MAIN    = 5'd6;
  localparam logic [4:0] S_MAIN_W  = 5'd7;
  localparam logic [4:0] S_FIN     = 5'd8;
  localparam logic [4:0] S_T1      = 5'd9;
  localparam logic [4:0] S_T2      = 5'd10;
  localparam logic [4:0] S_T3      = 5'd11;
  localparam logic [4:0] S_COMMIT  = 5'd12;
  localparam logic [4:0] S_CAP     = 5'd13;
  localparam logic [4:0] S_CONC    = 5'd14;
  localparam logic [4:0] S_CONC_W  = 5'd15;
  localparam logic [4:0] S_PRND    = 5'd16;
  localparam logic [4:0] S_PASS    = 5'd17;
  localparam logic [4:0] S_EMIT    = 5'd18;

  logic [4:0] state, state_next;
  logic [esn_pkg::CNT_W-1:0] i, i_next, k, k_next;
  logic [esn_pkg::CNT_W-1:0] ni_c;
  logic accept, trigger;

  assign ni_c = esn_pkg::CNT_W'(sts.ni);
  assign in_ready = (state == S_IDLE);
  assign accept = in_valid && in_ready;
  assign trigger = (in_item.opcode == esn_pkg::OP_SAMPLE) &&
                   (esn_pkg::CNT_W'(in_item.column_index) == ni_c - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      i <= '0;
      k <= '0;
    end else begin
      state <= state_next;
      i <= i_next;
      k <= k_next;
    end
  end

  always_comb begin
    state_next = state;
    i_next = i;
    k_next = k;
    cmd = '0;
    cmd.row = esn_pkg::ROW_W'(i);
    cmd.opk = esn_pkg::ROW_W'(k);
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (in_item.opcode)
            esn_pkg::OP_WEIGHT:  cmd.wr_weight = 1'b1;
            esn_pkg::OP_CONC:    cmd.wr_conc = 1'b1;
            esn_pkg::OP_RESTART: cmd.restart = 1'b1;
            esn_pkg::OP_SAMPLE: begin
              cmd.wr_sample = (esn_pkg::CNT_W'(in_item.column_index) < ni_c);
              if (trigger) begin
                cmd.start = 1'b1;
                i_next = '0;
                k_next = '0;
                state_next = S_INNER;
              end
            end
            default: ;
          endcase
        end
      end
      S_INNER: begin
        cmd.issue = 1'b1;
        cmd.first = (k == '0);
        cmd.mem_sel = esn_pkg::MEM_WEIGHT;
        cmd.src = esn_pkg::SRC_SAMPLE;
        cmd.col = esn_pkg::COL_W'(k) + 1'b1;
        k_next = k + 1'b1;
        if (k == ni_c - 1'b1) state_next = S_INNER_W;
      end
      S_INNER_W: if (!sts.busy) state_next = S_SCL_LO;
      S_SCL_LO: begin
        cmd.scale_lo = 1'b1;
        state_next = S_SCL_HI;
      end
      S_SCL_HI: begin
        cmd.scale_hi = 1'b1;
        state_next = S_SCL_SUM;
      end
      S_SCL_SUM: begin
        cmd.scale_sum = 1'b1;
        k_next = '0;
        state_next = S_MAIN;
      end
      S_MAIN: begin
        cmd.issue = 1'b1;
        cmd.mem_sel = esn_pkg::MEM_WEIGHT;
        if (k == '0) begin
          cmd.first = 1'b1;
          cmd.src = esn_pkg::SRC_BIAS;
          cmd.col = '0;
        end else begin
          cmd.src = esn_pkg::SRC_STATE;
          cmd.col = esn_pkg::COL_W'(MAX_INPUTS) + esn_pkg::COL_W'(k);
          cmd.opk = esn_pkg::ROW_W'(k - 1'b1);
        end
        k_next = k + 1'b1;
        if (k == sts.n) state_next = S_MAIN_W;
      end
      S_MAIN_W: if (!sts.busy) state_next = S_FIN;
      S_FIN: begin
        cmd.fin = 1'b1;
        state_next = S_T1;
      end
      S_T1: begin
        cmd.tanh1 = 1'b1;
        state_next = S_T2;
      end
      S_T2: begin
        cmd.tanh2 = 1'b1;
        state_next = S_T3;
      end
      S_T3: begin
        cmd.tanh3 = 1'b1;
        k_next = '0;
        if (i == sts.n - 1'b1) begin
          state_next = S_COMMIT;
        end else begin
          i_next = i + 1'b1;
          state_next = S_INNER;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        i_next = '0;
        state_next = S_CAP;
      end
      S_CAP: begin
        cmd.cap_res = 1'b1;
        cmd.opk = esn_pkg::ROW_W'(i);
        k_next = '0;
        state_next = sts.applied ? S_CONC : S_PASS;
      end
      S_CONC: begin
        cmd.issue = 1'b1;
        cmd.first = (k == '0);
        cmd.mem_sel = esn_pkg::MEM_CONC;
        cmd.src = esn_pkg::SRC_STATE;
        cmd.col = esn_pkg::COL_W'(k);
        k_next = k + 1'b1;
        if (k == sts.n - 1'b1) state_next = S_CONC_W;
      end
      S_CONC_W: if (!sts.busy) state_next = S_PRND;
      S_PRND: begin
        cmd.proj_rnd = 1'b1;
        state_next = S_EMIT;
      end
      S_PASS: begin
        cmd.proj_pass = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.last = (i == sts.n - 1'b1);
          if (cmd.last) begin
            cmd.step_done = 1'b1;
            state_next = S_IDLE;
          end else begin
            i_next = i + 1'b1;
            state_next = S_CAP;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free) else $error("result written over a waiting one");
  a_fin_settled: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN || state == S_PRND || state == S_SCL_LO) |-> !sts.busy)
    else $error("accumulator read while products are in flight");
  a_trigger: assert property (@(posedge clk) disable iff (rst)
    (accept && trigger) |=> (state == S_INNER && i == '0))
    else $error("final sample element did not start a step");

endmodule

// File: sv/esn_datapath.sv
// Datapath of the reservoir step: configuration, stores, MAC pipeline,
// tanh unit and output register. Depends on esn_pkg.
module esn_datapath #(
  parameter int RESERVOIR_SIZE = 32,
  parameter int MAX_INPUTS = 4,
  parameter int FRAC_BITS = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  esn_pkg::in_item_t  in_item,
  input  logic               cfg_valid,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  esn_pkg::cmd_t      cmd,
  output esn_pkg::status_t   sts,
  output logic               out_valid,
  input  logic               out_ready,
  output esn_pkg::out_item_t out_item
);

  localparam int AW = esn_pkg::ACC_W;
  localparam int WCOLS = 1 + MAX_INPUTS + RESERVOIR_SIZE;
  localparam int WDEPTH = RESERVOIR_SIZE * WCOLS;
  localparam int CDEPTH = RESERVOIR_SIZE * RESERVOIR_SIZE;
  localparam int WAW = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int CAW = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
  localparam int IW = (RESERVOIR_SIZE > 1) ? $clog2(RESERVOIR_SIZE) : 1;
  localparam int MW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int SH = 16 - FRAC_BITS;
  localparam logic signed [AW-1:0] HALF = AW'(64'sd1 <<< (FRAC_BITS - 1));
  localparam logic [AW-1:0] FOUR = AW'(64'd4 << FRAC_BITS);
  localparam logic [17:0] ONE = 18'(1 << FRAC_BITS);
  localparam logic [17:0] HALF16 = 18'((1 << SH) >> 1);

  // Configuration registers.
  logic signed [15:0] bias_scale, input_scale, initial_state;
  logic [15:0] washout_length;
  logic [2:0]  input_count;
  logic [5:0]  neuron_count;
  logic [15:0] step_count;
  logic        applied;

  always_ff @(posedge clk) begin
    if (rst) begin
      bias_scale <= 16'sd819;
      input_scale <= 16'sd4096;
      initial_state <= 16'sd0;
      washout_length <= 16'd0;
      input_count <= 3'd1;
      neuron_count <= 6'd32;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        esn_pkg::REG_BIAS_SCALE:  bias_scale <= cfg_data;
        esn_pkg::REG_INPUT_SCALE: input_scale <= cfg_data;
        esn_pkg::REG_INIT_STATE:  initial_state <= cfg_data;
        esn_pkg::REG_WASHOUT:     washout_length <= cfg_data;
        esn_pkg::REG_INPUT_COUNT: input_count <= cfg_data[2:0];
        esn_pkg::REG_NEURON_CNT:  neuron_count <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  assign sts.ni = (input_count == 3'd0) ? 4'd1 :
                  (32'(input_count) > MAX_INPUTS) ? 4'(MAX_INPUTS) : 4'(input_count);
  assign sts.n = (neuron_count == 6'd0) ? 7'd1 :
                 (32'(neuron_count) > RESERVOIR_SIZE) ? 7'(RESERVOIR_SIZE) :
                 7'(neuron_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      step_count <= '0;
      applied <= 1'b0;
    end else begin
      if (cmd.restart) step_count <= '0;
      else if (cmd.step_done && step_count != 16'hFFFF) step_count <= step_count + 1'b1;
      if (cmd.start) applied <= (step_count >= washout_length);
    end
  end
  assign sts.applied = applied;

  // Weight and conceptor memories.
  logic signed [15:0] wmem [WDEPTH];
  logic signed [15:0] cmem [CDEPTH];
  logic signed [15:0] rd_w, rd_c;
  logic wr_w_ok, wr_c_ok;
  logic [WAW-1:0] wa_wr, wa_rd;
  logic [CAW-1:0] ca_wr, ca_rd;

  assign wr_w_ok = cmd.wr_weight && (32'(in_item.row_index) < RESERVOIR_SIZE) &&
                   (32'(in_item.column_index) < WCOLS);
  assign wr_c_ok = cmd.wr_conc && (32'(in_item.row_index) < RESERVOIR_SIZE) &&
                   (32'(in_item.column_index) < RESERVOIR_SIZE);
  assign wa_wr = WAW'(32'(in_item.row_index) * WCOLS + 32'(in_item.column_index));
  assign ca_wr = CAW'(32'(in_item.row_index) * RESERVOIR_SIZE + 32'(in_item.column_index));
  assign wa_rd = WAW'(32'(cmd.row) * WCOLS + 32'(cmd.col));
  assign ca_rd = CAW'(32'(cmd.row) * RESERVOIR_SIZE + 32'(cmd.col));

  always_ff @(posedge clk) begin
    if (wr_w_ok) wmem[wa_wr] <= in_item.data_word;
    rd_w <= wmem[wa_rd];
  end

  always_ff @(posedge clk) begin
    if (wr_c_ok) cmem[ca_wr] <= in_item.data_word;
    rd_c <= cmem[ca_rd];
  end

  // Sample buffer, neuron state and fresh values.
  logic signed [15:0] sbuf [MAX_INPUTS];
  logic signed [15:0] nstate [RESERVOIR_SIZE];
  logic signed [15:0] fresh [RESERVOIR_SIZE];
  logic signed [15:0] fresh_val;

  always_ff @(posedge clk) begin
    if (cmd.wr_sample) sbuf[in_item.column_index[MW-1:0]] <= in_item.data_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < RESERVOIR_SIZE; j++) nstate[j] <= '0;
    end else if (cmd.restart) begin
      for (int j = 0; j < RESERVOIR_SIZE; j++) nstate[j] <= initial_state;
    end else if (cmd.commit) begin
      for (int j = 0; j < RESERVOIR_SIZE; j++)
        if (j < 32'(sts.n)) nstate[j] <= fresh[j];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tanh3) fresh[cmd.row[IW-1:0]] <= fresh_val;
  end

  // MAC pipeline: operand latch, product, accumulate.
  logic signed [15:0] b0, opa;
  logic signed [31:0] p1;
  logic signed [AW-1:0] acc;
  logic v1, v2, f1, f2, sel1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    f1 <= cmd.first;
    sel1 <= cmd.mem_sel;
    f2 <= f1;
    unique case (cmd.src)
      esn_pkg::SRC_SAMPLE: b0 <= sbuf[cmd.opk[MW-1:0]];
      esn_pkg::SRC_BIAS:   b0 <= bias_scale;
      default:             b0 <= nstate[cmd.opk[IW-1:0]];
    endcase
    p1 <= opa * b0;
    if (v2) acc <= f2 ? AW'(p1) : acc + AW'(p1);
  end

  assign opa = (sel1 == esn_pkg::MEM_CONC) ? rd_c : rd_w;
  assign sts.busy = v1 || v2;

  // Input scaling in two partial products, then sum and tanh.
  logic signed [34:0] p_lo;
  logic signed [32:0] p_hi;
  logic signed [AW-1:0] scaled, xr, apos;
  logic neg, big;
  logic [3:0] seg;
  logic [13:0] fr;
  logic [16:0] y16, t_lo, t_hi;
  logic [17:0] t;
  logic [17:0] ymag;
  logic signed [18:0] ys;
  logic [28:0] dfr;

  assign apos = xr[AW-1] ? -xr : xr;
  assign t = 18'(apos[17:0] << SH);
  assign t_lo = esn_pkg::tanh_tab({1'b0, seg});
  assign t_hi = esn_pkg::tanh_tab(5'({1'b0, seg}) + 5'd1);
  assign dfr = 29'(t_hi - t_lo) * 29'(fr);
  assign ymag = big ? ONE : 18'((18'(y16) + HALF16) >> SH);
  assign ys = neg ? -$signed({1'b0, ymag}) : $signed({1'b0, ymag});
  assign fresh_val = esn_pkg::sat16(AW'(ys));

  always_ff @(posedge clk) begin
    if (cmd.scale_lo) p_lo <= input_scale * $signed({1'b0, acc[17:0]});
    if (cmd.scale_hi) p_hi <= input_scale * $signed(acc[34:18]);
    if (cmd.scale_sum) scaled <= ((AW'(p_hi) <<< 18) + AW'(p_lo)) >>> FRAC_BITS;
    if (cmd.fin) xr <= (acc + scaled + HALF) >>> FRAC_BITS;
    if (cmd.tanh1) begin
      neg <= xr[AW-1];
      big <= $unsigned(apos) >= FOUR;
      seg <= t[17:14];
      fr <= t[13:0];
    end
    if (cmd.tanh2) y16 <= t_lo + 17'((dfr + 29'd8192) >> 14);
  end

  // Result assembly and output register.
  logic signed [15:0] res, proj;

  always_ff @(posedge clk) begin
    if (cmd.cap_res) res <= nstate[cmd.opk[IW-1:0]];
    if (cmd.proj_rnd) proj <= esn_pkg::sat16((acc + HALF) >>> FRAC_BITS);
    else if (cmd.proj_pass) proj <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.emit) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_item.neuron_index <= cmd.row[4:0];
      out_item.reservoir_value <= res;
      out_item.projected_value <= proj;
      out_item.projection_applied <= applied;
      out_item.last_neuron <= cmd.last;
    end
  end

  assign sts.out_free = !out_valid || out_ready;

endmodule

// File: sv/esn_reservoir_conceptor_step.sv
// Top level of the echo state reservoir step with conceptor projection.
// Depends on esn_pkg, esn_ctrl and esn_datapath.
//
// Usage. Items arrive on in_valid/in_ready/in_item. A weight or conceptor
// item writes one memory entry, a restart item loads every neuron with the
// initial state and clears the step count, and a sample item stores one
// element. The element with index input_count-1 starts a step. Each such
// step returns neuron_count result items on out_valid/out_ready/out_item,
// in neuron order, the final one flagged by last_neuron.
// Configuration registers are written through cfg_valid/cfg_index/cfg_data;
// cfg_ready is always high, and writes are meant only while the block idles.
// Sequencing. Load, restart and non-final sample items leave the block idle
// and ready for the next item. A step is worked by a single multiply-accumulate
// pipeline: per neuron the update (input terms, input scaling, bias and
// recurrent terms, then tanh), then a commit of the new states, then per neuron
// the projection through the conceptor after the washout, or a pass of the
// stored state before it. No new item is taken until the step has ended.
// Reset restores the register defaults and clears all neurons; the memories
// keep whatever they held. A stalled receiver holds one result in the output
// register and pauses the step until it is taken; after the final result the
// block takes new items while that result still waits.
module esn_reservoir_conceptor_step #(
  parameter int RESERVOIR_SIZE = 32,
  parameter int MAX_INPUTS = 4,
  parameter int FRAC_BITS = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  esn_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output esn_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  esn_pkg::cmd_t    cmd;
  esn_pkg::status_t sts;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  esn_ctrl #(
    .MAX_INPUTS(MAX_INPUTS)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .sts(sts),
    .cmd(cmd)
  );

  esn_datapath #(
    .RESERVOIR_SIZE(RESERVOIR_SIZE),
    .MAX_INPUTS(MAX_INPUTS),
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk(clk),
    .rst(rst),
    .in_item(in_item),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cmd(cmd),
    .sts(sts),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item)
  );

endmodule

// File: sim/esn_reservoir_conceptor_step_test.sv
// Self-checking testbench for the echo state reservoir step with conceptor projection.
// Depends on esn_pkg and esn_reservoir_conceptor_step; needs nothing else.
`timescale 1ns / 1ps

module esn_reservoir_conceptor_step_test;

  localparam int NRES = 32;
  localparam int NIN = 4;
  localparam int WCOL = 1 + NIN + NRES;

  // Each configuration write travels through the stimulus queue as well,
  // so that writes fall only at points where the block has been drained.
  typedef struct {
    bit         is_cfg;
    bit         drain;
    logic [2:0] idx;
    logic [15:0] val;
    esn_pkg::in_item_t item;
  } stim_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  esn_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 0;
  esn_pkg::out_item_t out_item;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  esn_reservoir_conceptor_step dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // Predictor state, mirroring the block's registers and memories.
  logic signed [15:0] p_bias_scale, p_input_scale, p_init_state;
  logic [15:0] p_washout;
  logic [2:0]  p_in_cnt;
  logic [5:0]  p_neu_cnt;
  logic signed [15:0] weights [NRES*WCOL];
  logic signed [15:0] concept [NRES*NRES];
  logic signed [15:0] neurons [NRES];
  logic signed [15:0] samples [NIN];
  int unsigned steps_done;

  stim_t pending_stim[$];
  esn_pkg::out_item_t expected_results[$];
  int errors = 0;
  bit stim_done = 0;

  function automatic int eff_in();
    if (p_in_cnt == 0) return 1;
    return (p_in_cnt > NIN) ? NIN : p_in_cnt;
  endfunction

  function automatic int eff_neu();
    if (p_neu_cnt == 0) return 1;
    return (p_neu_cnt > NRES) ? NRES : p_neu_cnt;
  endfunction

  // Floor shift right of a signed value.
  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rnd_q(longint v);
    return floor_shr(v + (64'sd1 <<< 11), 12);
  endfunction

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] tanh_q(longint x);
    int q16 [17] = '{0, 16051, 30285, 41625, 49911, 55593, 59320, 61694, 63179,
                     64096, 64659, 65000, 65212, 65339, 65417, 65464, 65492};
    longint a, t, fr, y16, y;
    int seg;
    a = (x < 0) ? -x : x;
    if (a >= 4 * 4096) y = 4096;
    else begin
      t = a << 4;
      seg = int'(t >> 14);
      fr = t & 64'h3FFF;
      y16 = q16[seg] + (((longint'(q16[seg+1] - q16[seg])) * fr + 8192) >>> 14);
      y = (y16 + 8) >>> 4;
    end
    return clip16((x < 0) ? -y : y);
  endfunction

  // Applies one accepted item to the predictor and queues its results.
  task automatic predict_reservoir(input esn_pkg::in_item_t it);
    int ni, n;
    longint inner, rec, acc, s;
    logic signed [15:0] fresh [NRES];
    logic signed [15:0] proj;
    bit applied;
    esn_pkg::out_item_t r;
    ni = eff_in();
    n = eff_neu();
    case (it.opcode)
      esn_pkg::OP_WEIGHT: begin
        if (it.column_index < WCOL) weights[it.row_index*WCOL + it.column_index] = it.data_word;
      end
      esn_pkg::OP_CONC: begin
        if (it.column_index < NRES) concept[it.row_index*NRES + it.column_index] = it.data_word;
      end
      esn_pkg::OP_RESTART: begin
        for (int i = 0; i < NRES; i++) neurons[i] = p_init_state;
        steps_done = 0;
      end
      default: begin
        if (it.column_index < ni) begin
          samples[it.column_index] = it.data_word;
          if (it.column_index == ni - 1) begin
            for (int i = 0; i < n; i++) begin
              inner = 0;
              rec = 0;
              for (int k = 0; k < ni; k++)
                inner += longint'(weights[i*WCOL+1+k]) * longint'(samples[k]);
              for (int k = 0; k < n; k++)
                rec += longint'(weights[i*WCOL+1+NIN+k]) * longint'(neurons[k]);
              acc = longint'(p_bias_scale) * longint'(weights[i*WCOL]) +
                    floor_shr(longint'(p_input_scale) * inner, 12) + rec;
              fresh[i] = tanh_q(rnd_q(acc));
            end
            for (int i = 0; i < n; i++) neurons[i] = fresh[i];
            applied = steps_done >= p_washout;
            for (int i = 0; i < n; i++) begin
              proj = fresh[i];
              if (applied) begin
                s = 0;
                for (int k = 0; k < n; k++)
                  s += longint'(concept[i*NRES+k]) * longint'(fresh[k]);
                proj = clip16(rnd_q(s));
              end
              r.neuron_index = i[4:0];
              r.reservoir_value = fresh[i];
              r.projected_value = proj;
              r.projection_applied = applied;
              r.last_neuron = (i == n - 1);
              expected_results.push_back(r);
            end
            if (steps_done < 65535) steps_done++;
          end
        end
      end
    endcase
  endtask

  task automatic apply_setting(input logic [2:0] idx, input logic [15:0] v);
    case (idx)
      esn_pkg::REG_BIAS_SCALE:  p_bias_scale = v;
      esn_pkg::REG_INPUT_SCALE: p_input_scale = v;
      esn_pkg::REG_INIT_STATE:  p_init_state = v;
      esn_pkg::REG_WASHOUT:     p_washout = v;
      esn_pkg::REG_INPUT_COUNT: p_in_cnt = v[2:0];
      default:                  p_neu_cnt = v[5:0];
    endcase
  endtask

  // Stimulus builders.
  function automatic esn_pkg::in_item_t mk(logic [1:0] op, int row, int col, logic [15:0] d);
    esn_pkg::in_item_t it;
    it.opcode = op;
    it.row_index = row[4:0];
    it.column_index = col[5:0];
    it.data_word = d;
    return it;
  endfunction

  task automatic push_item(input esn_pkg::in_item_t it);
    stim_t s;
    s.is_cfg = 0;
    s.drain = 0;
    s.item = it;
    pending_stim.push_back(s);
  endtask

  task automatic push_cfg(input logic [2:0] idx, input logic [15:0] v);
    stim_t s;
    s.is_cfg = 1;
    s.drain = 1;
    s.idx = idx;
    s.val = v;
    pending_stim.push_back(s);
  endtask

  task automatic push_drain();
    stim_t s;
    s.is_cfg = 0;
    s.drain = 1;
    pending_stim.push_back(s);
  endtask

  function automatic logic [15:0] rnd_word();
    case ($urandom_range(0, 5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 8191) - 4096);
      default: return 16'($urandom());
    endcase
  endfunction

  // Writes every weight and conceptor entry with small-ish random values.
  task automatic load_all(input int spread);
    for (int r = 0; r < NRES; r++)
      for (int c = 0; c < WCOL; c++)
        push_item(mk(esn_pkg::OP_WEIGHT, r, c,
                     16'($signed($urandom_range(0, 2*spread)) - spread)));
    for (int r = 0; r < NRES; r++)
      for (int c = 0; c < NRES; c++)
        push_item(mk(esn_pkg::OP_CONC, r, c,
                     16'($signed($urandom_range(0, 2*spread)) - spread)));
  endtask

  // A full sample: elements in order, the last one triggering a step.
  task automatic push_sample(input int ni);
    for (int k = 0; k < ni; k++)
      push_item(mk(esn_pkg::OP_SAMPLE, $urandom_range(0, 31), k, rnd_word()));
  endtask

  // Effective input count as it will stand once the queued writes are applied.
  function automatic int eff_in_of(ref stim_t q[$]);
    logic [2:0] v;
    v = p_in_cnt;
    foreach (q[i]) if (q[i].is_cfg && q[i].idx == esn_pkg::REG_INPUT_COUNT) v = q[i].val[2:0];
    if (v == 0) return 1;
    return (v > NIN) ? NIN : v;
  endfunction

  initial begin
    int ni, kind;
    p_bias_scale = 819;
    p_input_scale = 4096;
    p_init_state = 0;
    p_washout = 0;
    p_in_cnt = 1;
    p_neu_cnt = 32;
    for (int i = 0; i < NRES; i++) neurons[i] = 0;
    for (int i = 0; i < NIN; i++) samples[i] = 0;
    for (int i = 0; i < NRES*WCOL; i++) weights[i] = 0;
    for (int i = 0; i < NRES*NRES; i++) concept[i] = 0;
    steps_done = 0;

    // Directed part: extremes, every operation, out-of-range indices, the
    // register clamps and the step trigger rules. The full memory load comes
    // first, since a step at full size reads every entry.
    load_all(600);
    push_item(mk(esn_pkg::OP_WEIGHT, 31, 36, 16'h7FFF));
    push_item(mk(esn_pkg::OP_WEIGHT, 31, 37, 16'h1234));    // column past the row: ignored
    push_item(mk(esn_pkg::OP_WEIGHT, 0, 63, 16'h8000));     // ignored
    push_item(mk(esn_pkg::OP_CONC, 31, 31, 16'h8000));
    push_item(mk(esn_pkg::OP_CONC, 5, 32, 16'h7FFF));       // ignored
    push_item(mk(esn_pkg::OP_SAMPLE, 0, 0, 16'h7FFF));      // one input: starts a step
    push_item(mk(esn_pkg::OP_SAMPLE, 0, 1, 16'h1111));      // index beyond input_count
    push_item(mk(esn_pkg::OP_SAMPLE, 31, 0, 16'h8000));
    push_item(mk(esn_pkg::OP_RESTART, 0, 0, 16'hFFFF));
    push_cfg(esn_pkg::REG_INPUT_COUNT, 16'd0);              // acts as one
    push_cfg(esn_pkg::REG_NEURON_CNT, 16'd0);               // acts as one
    push_cfg(esn_pkg::REG_INIT_STATE, 16'h7FFF);
    push_cfg(esn_pkg::REG_WASHOUT, 16'd2);
    push_item(mk(esn_pkg::OP_RESTART, 0, 0, 0));
    push_sample(1);
    push_sample(1);
    push_sample(1);
    push_cfg(esn_pkg::REG_INPUT_COUNT, 16'd7);              // acts as four
    push_cfg(esn_pkg::REG_NEURON_CNT, 16'd63);              // acts as the full reservoir
    push_cfg(esn_pkg::REG_BIAS_SCALE, 16'h7FFF);
    push_cfg(esn_pkg::REG_INPUT_SCALE, 16'h8000);
    push_sample(4);
    push_item(mk(esn_pkg::OP_SAMPLE, 0, 3, 16'h8000));      // final element alone
    push_item(mk(esn_pkg::OP_SAMPLE, 0, 1, 16'h7FFF));      // earlier element: no result
    push_cfg(esn_pkg::REG_INIT_STATE, 16'h8000);
    push_cfg(esn_pkg::REG_WASHOUT, 16'hFFFF);
    push_item(mk(esn_pkg::OP_RESTART, 3, 9, 16'h0));
    push_sample(4);

    // Random part: mostly well-formed samples with an occasional weight or
    // conceptor rewrite, restart or stray element; settings change between phases.
    for (int phase = 0; phase < 10; phase++) begin
      push_cfg(esn_pkg::REG_BIAS_SCALE, rnd_word());
      push_cfg(esn_pkg::REG_INPUT_SCALE, rnd_word());
      push_cfg(esn_pkg::REG_INIT_STATE, rnd_word());
      push_cfg(esn_pkg::REG_WASHOUT, 16'($urandom_range(0, 4)));
      push_cfg(esn_pkg::REG_INPUT_COUNT, 16'($urandom_range(0, 7)));
      push_cfg(esn_pkg::REG_NEURON_CNT, 16'((phase % 3 == 0) ? $urandom_range(0, 63)
                                                             : $urandom_range(1, 6)));
      ni = eff_in_of(pending_stim);
      for (int j = 0; j < 8; j++) begin
        kind = $urandom_range(0, 9);
        if (kind < 6) push_sample(ni);
        else if (kind == 6) push_item(mk(esn_pkg::OP_WEIGHT, $urandom_range(0, 31),
                                         $urandom_range(0, 63), rnd_word()));
        else if (kind == 7) push_item(mk(esn_pkg::OP_CONC, $urandom_range(0, 31),
                                         $urandom_range(0, 63), rnd_word()));
        else if (kind == 8) push_item(mk(esn_pkg::OP_RESTART, $urandom_range(0, 31),
                                         $urandom_range(0, 63), 16'($urandom())));
        else push_item(mk(esn_pkg::OP_SAMPLE, $urandom_range(0, 31),
                          $urandom_range(0, 63), rnd_word()));
      end
      if (phase == 4) push_drain();    // sender holds off until all results are in
    end
    stim_done = 1;
  end

  // Driver: presents queued items with random gaps. A drain point waits until
  // every expected result has come plus a settling pause.
  int gap = 0;
  int settle = 0;
  bit feeding = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
      cfg_valid <= 0;
    end else begin
      if (cfg_valid && cfg_ready) cfg_valid <= 0;
      if (in_valid && in_ready) begin
        in_valid <= 0;
        predict_reservoir(in_item);
        gap = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2) : $urandom_range(5, 40);
        if ($urandom_range(0, 3) == 0) gap = 0;
      end else if (!in_valid && !cfg_valid && pending_stim.size() > 0) begin
        if (gap > 0) gap--;
        else if (pending_stim[0].drain && (expected_results.size() > 0 || in_valid)) settle = 0;
        else if (pending_stim[0].drain && settle < 40) settle++;
        else if (pending_stim[0].is_cfg) begin
          cfg_index <= pending_stim[0].idx;
          cfg_data <= pending_stim[0].val;
          cfg_valid <= 1;
          apply_setting(pending_stim[0].idx, pending_stim[0].val);
          void'(pending_stim.pop_front());
          settle = 40;
        end else if (pending_stim[0].drain) begin
          void'(pending_stim.pop_front());
          settle = 0;
        end else begin
          in_item <= pending_stim[0].item;
          in_valid <= 1;
          void'(pending_stim.pop_front());
          // The next drain point needs a fresh pause.
          settle = 0;
        end
      end
    end
  end

  // Monitor and receiver stalls: compare each accepted result with the oldest
  // expectation, the whole item in one check.
  always @(posedge clk) begin
    esn_pkg::out_item_t e;
    if (rst) out_ready <= 0;
    else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_item);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (out_item !== e) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, out_item);
            errors++;
          end
        end
      end
      out_ready <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 49) == 0);
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 0;
    wait (stim_done && pending_stim.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) $display("PASS esn_reservoir_conceptor_step");
    else $display("FAIL esn_reservoir_conceptor_step");
    $finish;
  end

  // Timeout for the whole run: every step, plus stalls and loading.
  initial begin
    #80ms;
    $display("FAIL esn_reservoir_conceptor_step");
    $finish;
  end

endmodule
